// ----- design/ttf_pkg.sv -----
// ttf_pkg: shared constants and command/status types for the tangent frame core
// used by ttf_ctrl, ttf_dp and triangle_tangent_frame_core; no dependencies
`default_nettype none
package ttf_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FIELD_W         = 32;
	localparam int IN_FIELDS       = 5;
	localparam int OUT_W           = 16;
	localparam int OUT_COMPS       = 6;
	localparam int NORM_BITS       = 31;
	localparam int FRAC_BITS       = 14;
	localparam int QUO_W           = FRAC_BITS + 1;
	localparam int QIDX_W          = $clog2(QUO_W);
	localparam int SUM_W           = 64;
	localparam int LEN_W           = SUM_W / 2;
	localparam int REM_W           = NORM_BITS + FRAC_BITS + 1;
	localparam int STEP_W          = $clog2(SUM_W / 2);
	localparam int SEL_W           = 5;

	localparam logic [STEP_W-1:0] SQRT_LAST_STEP = STEP_W'(SUM_W / 2 - 1);
	localparam logic [STEP_W-1:0] DIV_LAST_STEP  = STEP_W'(QUO_W - 1);
	localparam logic [1:0]        COMP_LAST      = 2'd2;

	// multiplier schedule: det pair, tangent pairs, bitangent pairs, squares
	localparam logic [SEL_W-1:0] MUL_DET_FIRST  = 5'd0;
	localparam logic [SEL_W-1:0] MUL_T_FIRST    = 5'd2;
	localparam logic [SEL_W-1:0] MUL_B_FIRST    = 5'd8;
	localparam logic [SEL_W-1:0] MUL_CROSS_LAST = 5'd13;
	localparam logic [SEL_W-1:0] MUL_SQ_FIRST   = 5'd14;

	typedef struct packed {
		logic              hold_wr;
		logic              corner;
		logic              delta_ld;
		logic              mul_go;
		logic [SEL_W-1:0]  mul_sel;
		logic              vec;
		logic [1:0]        comp;
		logic [STEP_W-1:0] step;
		logic              lz_init;
		logic              lz_step;
		logic              shift_go;
		logic              sqrt_init;
		logic              sqrt_step;
		logic              div_init;
		logic              div_step;
		logic              div_wr;
		logic              zero_vec;
		logic              det_zero_wr;
		logic              out_ld;
	} ttf_cmd_t;

	typedef struct packed {
		logic det_zero;
		logic vec_zero;
		logic lz_done;
	} ttf_sts_t;

endpackage
`default_nettype wire

// ----- design/ttf_ctrl.sv -----
// ttf_ctrl: corner counter, sequencer and output valid for the tangent frame core
// depends on ttf_pkg
`default_nettype none
module ttf_ctrl
	import ttf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_valid,
	output logic          s_ready,
	output logic          m_valid,
	input  wire logic     m_ready,
	input  wire ttf_sts_t sts,
	output ttf_cmd_t      cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_MDRN  = 4'd2;
	localparam logic [3:0] S_DETC  = 4'd3;
	localparam logic [3:0] S_LZI   = 4'd4;
	localparam logic [3:0] S_LZ    = 4'd5;
	localparam logic [3:0] S_SHIFT = 4'd6;
	localparam logic [3:0] S_SQ    = 4'd7;
	localparam logic [3:0] S_SQDRN = 4'd8;
	localparam logic [3:0] S_SQI   = 4'd9;
	localparam logic [3:0] S_SQRT  = 4'd10;
	localparam logic [3:0] S_DIVI  = 4'd11;
	localparam logic [3:0] S_DIV   = 4'd12;
	localparam logic [3:0] S_DIVW  = 4'd13;
	localparam logic [3:0] S_NEXT  = 4'd14;
	localparam logic [3:0] S_FIN   = 4'd15;

	logic [3:0]        state_q, state_d;
	logic [1:0]        cnt_q;
	logic [SEL_W-1:0]  k_q;
	logic [1:0]        i_q;
	logic [STEP_W-1:0] step_q;
	logic              vec_q;
	logic              m_valid_q;
	logic              accept;

	assign s_ready = (state_q == S_IDLE);
	assign accept  = s_valid && s_ready;
	assign m_valid = m_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.corner  = cnt_q[0];
		cmd.vec     = vec_q;
		cmd.comp    = i_q;
		cmd.step    = step_q;
		cmd.mul_sel = k_q;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!cnt_q[1]) begin
						cmd.hold_wr = 1'b1;
					end else begin
						cmd.delta_ld = 1'b1;
						state_d      = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				if (k_q == MUL_CROSS_LAST) state_d = S_MDRN;
			end
			S_MDRN: state_d = S_DETC;
			S_DETC: begin
				if (sts.det_zero) begin
					cmd.det_zero_wr = 1'b1;
					state_d         = S_FIN;
				end else begin
					state_d = S_LZI;
				end
			end
			S_LZI: begin
				cmd.lz_init = 1'b1;
				state_d     = S_LZ;
			end
			S_LZ: begin
				if (sts.vec_zero) begin
					cmd.zero_vec = 1'b1;
					state_d      = S_NEXT;
				end else if (sts.lz_done) begin
					state_d = S_SHIFT;
				end else begin
					cmd.lz_step = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.shift_go = 1'b1;
				if (i_q == COMP_LAST) state_d = S_SQ;
			end
			S_SQ: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MUL_SQ_FIRST + SEL_W'(i_q);
				if (i_q == COMP_LAST) state_d = S_SQDRN;
			end
			S_SQDRN: state_d = S_SQI;
			S_SQI: begin
				cmd.sqrt_init = 1'b1;
				state_d       = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (step_q == '0) state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) state_d = S_DIVW;
			end
			S_DIVW: begin
				cmd.div_wr = 1'b1;
				state_d    = (i_q == COMP_LAST) ? S_NEXT : S_DIVI;
			end
			S_NEXT: state_d = vec_q ? S_FIN : S_LZI;
			S_FIN: begin
				if (!m_valid_q || m_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			k_q       <= '0;
			i_q       <= '0;
			step_q    <= '0;
			vec_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.hold_wr) cnt_q <= cnt_q + 2'd1;
			else if (cmd.delta_ld) cnt_q <= '0;
			if (cmd.delta_ld) k_q <= MUL_DET_FIRST;
			else if (state_q == S_MUL) k_q <= k_q + SEL_W'(1);
			if (state_q == S_LZI) begin
				i_q <= '0;
			end else if (state_q == S_SHIFT || state_q == S_SQ || state_q == S_DIVW) begin
				i_q <= (i_q == COMP_LAST) ? 2'd0 : i_q + 2'd1;
			end
			if (state_q == S_SQI) step_q <= SQRT_LAST_STEP;
			else if (state_q == S_DIVI) step_q <= DIV_LAST_STEP;
			else if (state_q == S_SQRT || state_q == S_DIV) step_q <= step_q - STEP_W'(1);
			if (cmd.delta_ld) vec_q <= 1'b0;
			else if (state_q == S_NEXT) vec_q <= 1'b1;
			if (cmd.out_ld) m_valid_q <= 1'b1;
			else if (m_ready) m_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- design/ttf_dp.sv -----
// ttf_dp: corner store, shared multiplier, accumulators, normaliser, isqrt and divider
// depends on ttf_pkg; driven by ttf_ctrl
`default_nettype none
module ttf_dp
	import ttf_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [FIELD_W*IN_FIELDS-1:0]  in_data,
	input  wire ttf_cmd_t                      cmd,
	output ttf_sts_t                           sts,
	output logic [OUT_W*OUT_COMPS-1:0]         out_data,
	output logic                               out_deg
);

	localparam int DW   = COORD_WIDTH + 1;
	localparam int OW   = (DW > 32) ? DW : 32;
	localparam int PW   = 2 * DW;
	localparam int AW   = PW + 1;
	localparam int MW   = PW;
	localparam int TOPW = $clog2(MW + 1);

	localparam logic [1:0] GRP_DET = 2'd0;
	localparam logic [1:0] GRP_TAN = 2'd1;
	localparam logic [1:0] GRP_BIT = 2'd2;
	localparam logic [1:0] GRP_SUM = 2'd3;

	function automatic logic signed [DW-1:0] sx(input logic [COORD_WIDTH-1:0] x);
		return $signed({x[COORD_WIDTH-1], x});
	endfunction

	function automatic logic [1:0] sel_grp(input logic [SEL_W-1:0] s);
		logic [1:0] g;
		if (s < MUL_T_FIRST) g = GRP_DET;
		else if (s < MUL_B_FIRST) g = GRP_TAN;
		else if (s < MUL_SQ_FIRST) g = GRP_BIT;
		else g = GRP_SUM;
		return g;
	endfunction

	function automatic logic [1:0] sel_comp(input logic [SEL_W-1:0] s);
		logic [SEL_W-1:0] r;
		if (s < MUL_T_FIRST) r = '0;
		else if (s < MUL_B_FIRST) r = (s - MUL_T_FIRST) >> 1;
		else if (s < MUL_SQ_FIRST) r = (s - MUL_B_FIRST) >> 1;
		else r = s - MUL_SQ_FIRST;
		return r[1:0];
	endfunction

	logic [COORD_WIDTH-1:0]  fld [IN_FIELDS];
	logic [COORD_WIDTH-1:0]  hold_q [2][IN_FIELDS];
	logic signed [DW-1:0]    e1_q [3];
	logic signed [DW-1:0]    e2_q [3];
	logic signed [DW-1:0]    du1_q, dv1_q, du2_q, dv2_q;
	logic signed [OW-1:0]    opa, opb;
	logic [1:0]              cg, cc, pg, pc;
	logic                    csub, psub;
	logic signed [2*OW-1:0]  prod_s1;
	logic                    pv_s1;
	logic [SEL_W-1:0]        psel_s1;
	logic signed [AW-1:0]    pext;
	logic signed [AW-1:0]    det_q;
	logic signed [AW-1:0]    tacc_q [3];
	logic signed [AW-1:0]    bacc_q [3];
	logic signed [AW-1:0]    vacc [3];
	logic                    vneg [3];
	logic [MW-1:0]           vmag [3];
	logic [MW-1:0]           wlz_q;
	logic [TOPW-1:0]         top_q;
	logic [MW+NORM_BITS-1:0] next;
	logic [MW+NORM_BITS-1:0] nsh;
	logic [NORM_BITS-1:0]    m_q [3];
	logic [SUM_W-1:0]        sum_q, sx_q, sr_q, bitv, tsum;
	logic [LEN_W-1:0]        len;
	logic [REM_W-1:0]        rem_q, dvs;
	logic [QUO_W-1:0]        quo_q;
	logic [OUT_W-1:0]        qv, qres;
	logic                    flip, qneg;
	logic [OUT_W-1:0]        rt_q [3];
	logic [OUT_W-1:0]        rb_q [3];
	logic                    deg_q;
	logic [OUT_W-1:0]        ot_q [3];
	logic [OUT_W-1:0]        ob_q [3];
	logic                    odeg_q;

	always_comb begin
		for (int f = 0; f < IN_FIELDS; f++) begin
			fld[f] = in_data[f*FIELD_W +: COORD_WIDTH];
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		cg   = sel_grp(cmd.mul_sel);
		cc   = sel_comp(cmd.mul_sel);
		csub = cmd.mul_sel[0];
		opa  = '0;
		opb  = '0;
		case (cg)
			GRP_DET: begin
				opa = OW'(csub ? du2_q : du1_q);
				opb = OW'(csub ? dv1_q : dv2_q);
			end
			GRP_TAN: begin
				opa = OW'(csub ? dv1_q : dv2_q);
				opb = OW'(csub ? e2_q[cc] : e1_q[cc]);
			end
			GRP_BIT: begin
				opa = OW'(csub ? du2_q : du1_q);
				opb = OW'(csub ? e1_q[cc] : e2_q[cc]);
			end
			GRP_SUM: begin
				opa = OW'({1'b0, m_q[cmd.comp]});
				opb = opa;
			end
			default: ;
		endcase
	end

	assign pg   = sel_grp(psel_s1);
	assign pc   = sel_comp(psel_s1);
	assign psub = psel_s1[0];
	assign pext = AW'($signed(prod_s1[PW-1:0]));
	assign flip = det_q[AW-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vacc[i] = cmd.vec ? bacc_q[i] : tacc_q[i];
			vneg[i] = vacc[i][AW-1];
			vmag[i] = MW'(vneg[i] ? -vacc[i] : vacc[i]);
		end
	end

	// bring the largest magnitude into [2^30, 2^31)
	always_comb begin
		next = (MW+NORM_BITS)'(vmag[cmd.comp]);
		if (top_q > TOPW'(NORM_BITS)) nsh = next >> (top_q - TOPW'(NORM_BITS));
		else nsh = next << (TOPW'(NORM_BITS) - top_q);
	end

	assign bitv = SUM_W'(1) << {cmd.step, 1'b0};
	assign tsum = sr_q + bitv;
	assign len  = sr_q[LEN_W-1:0];
	assign dvs  = REM_W'(len) << cmd.step;
	assign qv   = OUT_W'(quo_q);
	assign qneg = vneg[cmd.comp] ^ flip;
	assign qres = qneg ? -qv : qv;

	assign sts.det_zero = (det_q == '0);
	assign sts.vec_zero = (wlz_q == '0);
	assign sts.lz_done  = wlz_q[MW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_wr) begin
			for (int f = 0; f < IN_FIELDS; f++) hold_q[cmd.corner][f] <= fld[f];
		end
		if (cmd.delta_ld) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= sx(hold_q[1][i]) - sx(hold_q[0][i]);
				e2_q[i] <= sx(fld[i]) - sx(hold_q[0][i]);
			end
			du1_q <= sx(hold_q[1][3]) - sx(hold_q[0][3]);
			dv1_q <= sx(hold_q[1][4]) - sx(hold_q[0][4]);
			du2_q <= sx(fld[3]) - sx(hold_q[0][3]);
			dv2_q <= sx(fld[4]) - sx(hold_q[0][4]);
		end

		prod_s1 <= opa * opb;
		psel_s1 <= cmd.mul_sel;
		if (pv_s1) begin
			case (pg)
				GRP_DET: det_q <= psub ? det_q - pext : pext;
				GRP_TAN: begin
					for (int i = 0; i < 3; i++) begin
						if (pc == 2'(i)) tacc_q[i] <= psub ? tacc_q[i] - pext : pext;
					end
				end
				GRP_BIT: begin
					for (int i = 0; i < 3; i++) begin
						if (pc == 2'(i)) bacc_q[i] <= psub ? bacc_q[i] - pext : pext;
					end
				end
				GRP_SUM: begin
					sum_q <= (pc == 2'd0) ? prod_s1[SUM_W-1:0] : sum_q + prod_s1[SUM_W-1:0];
				end
				default: ;
			endcase
		end

		if (cmd.lz_init) begin
			wlz_q <= vmag[0] | vmag[1] | vmag[2];
			top_q <= TOPW'(MW);
		end else if (cmd.lz_step) begin
			wlz_q <= wlz_q << 1;
			top_q <= top_q - TOPW'(1);
		end
		if (cmd.shift_go) m_q[cmd.comp] <= nsh[NORM_BITS-1:0];

		if (cmd.sqrt_init) begin
			sx_q <= sum_q;
			sr_q <= '0;
		end else if (cmd.sqrt_step) begin
			if (sx_q >= tsum) begin
				sx_q <= sx_q - tsum;
				sr_q <= (sr_q >> 1) + bitv;
			end else begin
				sr_q <= sr_q >> 1;
			end
		end

		if (cmd.div_init) begin
			rem_q <= (REM_W'(m_q[cmd.comp]) << FRAC_BITS) + REM_W'(len >> 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dvs) begin
				rem_q <= rem_q - dvs;
				quo_q[cmd.step[QIDX_W-1:0]] <= 1'b1;
			end
		end

		if (cmd.delta_ld) deg_q <= 1'b0;
		if (cmd.div_wr) begin
			if (cmd.vec) rb_q[cmd.comp] <= qres;
			else rt_q[cmd.comp] <= qres;
		end
		if (cmd.zero_vec) begin
			deg_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				if (cmd.vec) rb_q[i] <= '0;
				else rt_q[i] <= '0;
			end
		end
		if (cmd.det_zero_wr) begin
			deg_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				rt_q[i] <= '0;
				rb_q[i] <= '0;
			end
		end

		if (cmd.out_ld) begin
			for (int i = 0; i < 3; i++) begin
				ot_q[i] <= rt_q[i];
				ob_q[i] <= rb_q[i];
			end
			odeg_q <= deg_q;
		end
	end

	assign out_data = {ob_q[2], ob_q[1], ob_q[0], ot_q[2], ot_q[1], ot_q[0]};
	assign out_deg  = odeg_q;

endmodule
`default_nettype wire

// ----- design/triangle_tangent_frame_core.sv -----
// triangle_tangent_frame_core: top level, per-triangle unit tangent and bitangent
// depends on ttf_pkg, ttf_ctrl and ttf_dp
//
// channel   dir  tdata                               tuser
// s_axis    in   pos_x,pos_y,pos_z,tex_u,tex_v 5x32   -
// m_axis    out  tangent xyz, bitangent xyz 6x16     degenerate
//
// first and second corner of a triangle: stored, input stays ready
// third corner: determinant test, then per vector a normalise with one step per leading zero
// bit of its largest cross term, squares, isqrt and a divide per component, then a load
// zero determinant: straight to the load; a shared 33x33 multiplier, isqrt and divide bitwise
// input is refused while a triangle is worked on; a stalled result is held in m_axis
// arst_n clears the corner count and m_axis valid and returns s_axis to ready
`default_nettype none
module triangle_tangent_frame_core
	import ttf_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [FIELD_W*IN_FIELDS-1:0] s_axis_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [OUT_W*OUT_COMPS-1:0]        m_axis_tdata,  // tangent_x/y/z, bitangent_x/y/z
	output logic                              m_axis_tuser   // degenerate
);

	ttf_cmd_t cmd;
	ttf_sts_t sts;

	ttf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ttf_dp #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_axis_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (m_axis_tdata),
		.out_deg  (m_axis_tuser)
	);

endmodule
`default_nettype wire

// ----- design/ttf_checker.sv -----
// ttf_checker: port-level assertions for triangle_tangent_frame_core, bound to the top
// depends on triangle_tangent_frame_core ports only
`default_nettype none
module ttf_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [95:0]  m_axis_tdata,
	input wire logic         m_axis_tuser
);

	logic signed [15:0] c [6];
	logic               in_range;

	always_comb begin
		in_range = 1'b1;
		for (int i = 0; i < 6; i++) begin
			c[i] = $signed(m_axis_tdata[i*16 +: 16]);
			if (c[i] > 16'sd16384 || c[i] < -16'sd16384) in_range = 1'b0;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> in_range)
		else $error("component outside unit range");

	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[47:0] != 48'd0)
			&& (m_axis_tdata[95:48] != 48'd0))
		else $error("clean result with a zero vector");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared right after an input word");

endmodule

bind triangle_tangent_frame_core ttf_checker u_ttf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- verif/triangle_tangent_frame_core_tb.sv -----
// triangle_tangent_frame_core_tb: self-checking bench for the tangent frame core
// drives corner words on s_axis, predicts each triangle's frame and checks m_axis
// depends on ttf_pkg and triangle_tangent_frame_core
`default_nettype none
module triangle_tangent_frame_core_tb;
	import ttf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 3000000;
	localparam int ONE   = 32'h0001_0000;

	typedef logic signed [71:0] wide_t;
	typedef struct {
		logic [95:0] frame;
		logic        degenerate;
	} frame_t;
	typedef struct {
		logic [31:0] f [5];
		bit          typed;
		logic [95:0] frame;
		logic        degenerate;
	} corner_row_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready, m_axis_tuser;
	logic [FIELD_W*IN_FIELDS-1:0] s_axis_tdata;
	logic [OUT_W*OUT_COMPS-1:0]   m_axis_tdata;

	triangle_tangent_frame_core u_top (.*);

	frame_t      frames_due [$];
	corner_row_t rows [$];
	int          errors, cycles;
	int          send_idle, recv_stall;
	logic [1:0]  corner_cnt;
	logic signed [31:0] held [2][5];
	string       comp_name [6] = '{"tangent_x", "tangent_y", "tangent_z",
		"bitangent_x", "bitangent_y", "bitangent_z"};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0]  r;
		logic [127:0] t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	// scale to unit length in Q1.14, false if the vector is zero
	function automatic bit unit_vec(input wide_t c [3], input bit flip, output logic [15:0] o [3]);
		wide_t       mag [3];
		logic [63:0] m [3], sum, len, q;
		int          top, nb;
		top = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = c[i] < 0 ? -c[i] : c[i];
			nb = 0;
			for (int k = 0; k < 72; k++)
				if (mag[i][k])
					nb = k + 1;
			if (nb > top)
				top = nb;
		end
		if (top == 0) begin
			for (int i = 0; i < 3; i++)
				o[i] = 0;
			return 0;
		end
		for (int i = 0; i < 3; i++) begin
			m[i] = top > 31 ? 64'(mag[i] >> (top - 31)) : 64'(mag[i] << (31 - top));
			sum += m[i] * m[i];
		end
		len = isqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 16384 + (len >> 1)) / len;
			o[i] = ((c[i] < 0) != flip) ? 16'(-q) : 16'(q);
		end
		return 1;
	endfunction

	// advances the corner state; returns 1 and the frame on a third corner
	function automatic bit predict_frame(input logic [31:0] f [5], output frame_t r);
		wide_t       e1 [3], e2 [3], t [3], b [3], du1, dv1, du2, dv2, det;
		logic [15:0] tv [3], bv [3];
		bit          ok;
		if (corner_cnt < 2) begin
			for (int i = 0; i < 5; i++)
				held[corner_cnt[0]][i] = f[i];
			corner_cnt++;
			return 0;
		end
		corner_cnt = 0;
		for (int i = 0; i < 3; i++) begin
			e1[i] = wide_t'(held[1][i]) - wide_t'(held[0][i]);
			e2[i] = wide_t'($signed(f[i])) - wide_t'(held[0][i]);
		end
		du1 = wide_t'(held[1][3]) - wide_t'(held[0][3]);
		dv1 = wide_t'(held[1][4]) - wide_t'(held[0][4]);
		du2 = wide_t'($signed(f[3])) - wide_t'(held[0][3]);
		dv2 = wide_t'($signed(f[4])) - wide_t'(held[0][4]);
		det = du1 * dv2 - du2 * dv1;
		r.frame = 0;
		r.degenerate = 1;
		if (det == 0)
			return 1;
		for (int i = 0; i < 3; i++) begin
			t[i] = dv2 * e1[i] - dv1 * e2[i];
			b[i] = du1 * e2[i] - du2 * e1[i];
		end
		ok = unit_vec(t, det < 0, tv);
		ok = unit_vec(b, det < 0, bv) && ok;
		r.frame = {bv[2], bv[1], bv[0], tv[2], tv[1], tv[0]};
		r.degenerate = !ok;
		return 1;
	endfunction

	function automatic void add_corner(logic [31:0] x, y, z, u, v,
			bit typed = 0, logic [95:0] frame = 0, logic degenerate = 0);
		corner_row_t c;
		c.f = '{x, y, z, u, v};
		c.typed = typed;
		c.frame = frame;
		c.degenerate = degenerate;
		rows.insert(rows.size(), c);
	endfunction

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 * ONE)) - ONE);
			default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		endcase
	endfunction

	task automatic send_corner(corner_row_t c);
		frame_t p;
		while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {c.f[4], c.f[3], c.f[2], c.f[1], c.f[0]};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (predict_frame(c.f, p)) begin
			if (c.typed) begin
				p.frame = c.frame;
				p.degenerate = c.degenerate;
			end
			frames_due.insert(frames_due.size(), p);
		end
	endtask

	always @(posedge clk) begin
		frame_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (frames_due.size() == 0) begin
				$error("frame word with nothing expected");
				errors++;
			end else begin
				e = frames_due.pop_front();
				for (int i = 0; i < 6; i++)
					if (m_axis_tdata[16*i +: 16] !== e.frame[16*i +: 16]) begin
						$error("%s expected %0d got %0d", comp_name[i],
							$signed(e.frame[16*i +: 16]), $signed(m_axis_tdata[16*i +: 16]));
						errors++;
					end
				if (m_axis_tuser !== e.degenerate) begin
					$error("degenerate expected %0b got %0b", e.degenerate, m_axis_tuser);
					errors++;
				end
			end
		end
		m_axis_tready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("triangle_tangent_frame_core test failed");
			$finish;
		end
	end

	initial begin
		int mode, idx;
		logic [31:0] su, sv;
		errors = 0;
		cycles = 0;
		corner_cnt = 0;
		send_idle = 0;
		recv_stall = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		m_axis_tready = 0;

		// unit right triangle, uv aligned with xy
		add_corner(0, 0, 0, 0, 0);
		add_corner(ONE, 0, 0, ONE, 0);
		add_corner(0, ONE, 0, 0, ONE, 1, {16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384});
		// all uv equal: zero determinant
		add_corner(5, 6, 7, 9, 9);
		add_corner(-3, 2, 1, 9, 9);
		add_corner(8, 8, -8, 9, 9, 1, 96'd0, 1);
		// all corners at one point: both vectors of zero length
		add_corner(ONE, ONE, ONE, 0, 0);
		add_corner(ONE, ONE, ONE, ONE, 0);
		add_corner(ONE, ONE, ONE, 0, ONE, 1, 96'd0, 1);
		// mirrored uv: negative determinant
		add_corner(0, 0, 0, 0, 0);
		add_corner(ONE, 0, 0, -ONE, 0);
		add_corner(0, ONE, 0, 0, ONE, 1, {16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, -16'sd16384});
		// field extremes
		add_corner(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		add_corner(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
		add_corner(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		add_corner(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		add_corner(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
		add_corner(32'hffffffff, 0, 1, 32'h80000000, 32'h7fffffff);
		// tiny edges, one bit each
		add_corner(0, 0, 0, 0, 0);
		add_corner(1, 0, 0, 1, 0);
		add_corner(0, 0, 1, 0, 1);

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i])
			send_corner(rows[i]);
		rows.delete();

		for (int n = 0; n < 500; n++) begin
			case ((n / 125) % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 63; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 63; end
				default: begin send_idle = 6; recv_stall = 6; end
			endcase
			mode = $urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 2);
			idx = $urandom_range(0, 19);
			su = rand_coord(mode);
			sv = rand_coord(mode);
			for (int k = 0; k < 3; k++) begin
				corner_row_t c;
				for (int i = 0; i < 5; i++)
					c.f[i] = rand_coord(mode);
				// a few triangles with flat or repeated uv
				if (idx == 0) begin
					c.f[3] = su;
					c.f[4] = sv;
				end else if (idx == 1)
					c.f[4] = sv;
				c.typed = 0;
				send_corner(c);
			end
		end
		s_axis_tvalid <= 0;

		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("triangle_tangent_frame_core test passed");
		else
			$display("triangle_tangent_frame_core test failed");
		$finish;
	end
endmodule
`default_nettype wire
